FILE: hw/rtl/fta_pkg.sv
// Shared constants, codes and widths for the FAT12 table allocator.
package fta_pkg;

  localparam int ENTRIES       = 4096;
  localparam int CLUSTER_BYTES = 512;
  localparam int ENT_W         = $clog2(ENTRIES);
  localparam int PACKED_BYTES  = ((ENTRIES + 1) / 2) * 3;

  localparam int VAL_W  = 12;
  localparam int IDX_W  = 13;
  localparam int SIZE_W = 16;
  localparam int NEED_W = SIZE_W + 1;

  localparam logic [VAL_W-1:0] END_MARK    = 12'hFFF;
  localparam logic [VAL_W-1:0] MEDIA_MARK  = 12'hFF0;
  localparam logic [VAL_W-1:0] SECOND_MARK = 12'hFF1;
  localparam logic [VAL_W-1:0] BAD_MARK    = 12'hFF7;
  localparam logic [VAL_W-1:0] RESET_LAST  = 12'd2848;

  // floor(x / 3) = (x * DIV3_MUL) >> DIV3_SHIFT, exact for x below 2**16
  localparam logic [15:0] DIV3_MUL   = 16'd43691;
  localparam int          DIV3_SHIFT = 17;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_ALLOC = 2'd2;
  localparam logic [1:0] KIND_PACK  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

FILE: hw/rtl/fat12_table_allocator_top.sv
// Top level of the FAT12 table allocator: table memory and its sequencer.
//
// Usage: an item (kind, index, value, size_bytes) is transferred on the in_
// channel when in_valid and in_ready are both high; one result
// (entry_value, byte_value, cluster_count, status) comes back on the out_
// channel and is held until out_ready takes it. One item is in the block at
// a time; in_ready stays low from transfer until the result is taken.
// All work goes through one table memory with one write and one registered
// read port, under a small sequencer:
//   entry read: one registered table read; entry write: written at transfer;
//   packed byte read: divide by three, then two entry reads;
//   chain allocation: each entry scanned is read and checked, and each
//   entry linked after the first adds a link step.
// After reset the block sweeps the table once, one entry per cycle,
// loading 0xFF0, 0xFF1, zeros up to entry 2848 and 0xFF7 above; in_ready
// stays low during the sweep. cfg_we writes last_data_entry at once; it
// takes effect on an allocation already under way as well.
// A stalled receiver just holds the result in the output registers.
module fat12_table_allocator_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [fta_pkg::VAL_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_kind,
  input  logic [fta_pkg::IDX_W-1:0]  in_index,
  input  logic [fta_pkg::VAL_W-1:0]  in_value,
  input  logic [fta_pkg::SIZE_W-1:0] in_size_bytes,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [fta_pkg::VAL_W-1:0]  out_entry_value,
  output logic [7:0]                 out_byte_value,
  output logic [fta_pkg::VAL_W-1:0]  out_cluster_count,
  output logic [1:0]                 out_status
);

  localparam int EW = fta_pkg::ENT_W;
  localparam int VW = fta_pkg::VAL_W;
  localparam int IW = fta_pkg::IDX_W;
  localparam int NW = fta_pkg::NEED_W;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_PDIV  = 4'd3;
  localparam logic [3:0] S_PLO   = 4'd4;
  localparam logic [3:0] S_PHI   = 4'd5;
  localparam logic [3:0] S_PBYTE = 4'd6;
  localparam logic [3:0] S_ARD   = 4'd7;
  localparam logic [3:0] S_ACHK  = 4'd8;
  localparam logic [3:0] S_ALINK = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  // table memory
  logic [VW-1:0] fat_r [fta_pkg::ENTRIES];
  logic [VW-1:0] rdata_r;
  logic          mem_we;
  logic [EW-1:0] mem_waddr;
  logic [VW-1:0] mem_wdata;
  logic [EW-1:0] mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fat_r[mem_waddr] <= mem_wdata;
    end
    rdata_r <= fat_r[mem_raddr];
  end

  logic [3:0]    state_r, state_nxt;
  logic [EW-1:0] clr_r, clr_nxt;
  logic [VW-1:0] last_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [EW-1:0] pair_r, pair_nxt;
  logic [1:0]    part_r, part_nxt;
  logic [VW-1:0] lo_r, lo_nxt;
  logic          lo_ok_r, lo_ok_nxt;
  logic          hi_ok_r, hi_ok_nxt;
  logic [NW-1:0] need_r, need_nxt;
  logic [EW:0]   cursor_r, cursor_nxt;
  logic [EW-1:0] prev_r, prev_nxt;
  logic [EW-1:0] found_r, found_nxt;
  logic          have_prev_r, have_prev_nxt;
  logic [VW-1:0] ev_r, ev_nxt;
  logic [7:0]    bv_r, bv_nxt;
  logic [VW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    st_r, st_nxt;

  logic          in_xfer;
  logic          idx_in_range;
  logic [EW-1:0] lim;
  logic [28:0]   div_prod;
  logic [EW-1:0] div_q;
  logic [IW-1:0] div_rem;
  logic [IW-1:0] lo_addr;
  logic [IW-1:0] hi_addr;
  logic [NW-1:0] size_sum;
  logic [VW-1:0] clr_val;
  logic [VW-1:0] hi_val;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign in_xfer   = in_valid && in_ready;

  assign out_entry_value   = ev_r;
  assign out_byte_value    = bv_r;
  assign out_cluster_count = cnt_r;
  assign out_status        = st_r;

  assign idx_in_range = (in_index < IW'(fta_pkg::ENTRIES));

  // clamp the search limit to the last table entry
  assign lim = ({1'b0, last_r} > 13'(fta_pkg::ENTRIES - 1))
             ? EW'(fta_pkg::ENTRIES - 1) : last_r[EW-1:0];

  assign div_prod = 29'(idx_r) * 29'(fta_pkg::DIV3_MUL);
  assign div_q    = div_prod[fta_pkg::DIV3_SHIFT +: EW];
  assign div_rem  = idx_r - IW'(IW'(div_q) * IW'(3));

  assign lo_addr = IW'({pair_r, 1'b0});
  assign hi_addr = lo_addr + IW'(1);

  assign size_sum = NW'(in_size_bytes) + NW'(fta_pkg::CLUSTER_BYTES - 1);

  always_comb begin
    if (clr_r == EW'(0)) begin
      clr_val = fta_pkg::MEDIA_MARK;
    end else if (clr_r == EW'(1)) begin
      clr_val = fta_pkg::SECOND_MARK;
    end else if (VW'(clr_r) <= fta_pkg::RESET_LAST) begin
      clr_val = '0;
    end else begin
      clr_val = fta_pkg::BAD_MARK;
    end
  end

  assign hi_val = hi_ok_r ? rdata_r : '0;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    idx_nxt       = idx_r;
    pair_nxt      = pair_r;
    part_nxt      = part_r;
    lo_nxt        = lo_r;
    lo_ok_nxt     = lo_ok_r;
    hi_ok_nxt     = hi_ok_r;
    need_nxt      = need_r;
    cursor_nxt    = cursor_r;
    prev_nxt      = prev_r;
    found_nxt     = found_r;
    have_prev_nxt = have_prev_r;
    ev_nxt        = ev_r;
    bv_nxt        = bv_r;
    cnt_nxt       = cnt_r;
    st_nxt        = st_r;
    mem_we        = 1'b0;
    mem_waddr     = cursor_r[EW-1:0];
    mem_wdata     = fta_pkg::END_MARK;
    mem_raddr     = cursor_r[EW-1:0];

    unique case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = clr_val;
        clr_nxt   = clr_r + EW'(1);
        if (clr_r == EW'(fta_pkg::ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_raddr = in_index[EW-1:0];
        if (in_xfer) begin
          ev_nxt  = '0;
          bv_nxt  = '0;
          cnt_nxt = '0;
          st_nxt  = fta_pkg::ST_OK;
          idx_nxt = in_index;
          unique case (in_kind)
            fta_pkg::KIND_READ: begin
              if (idx_in_range) begin
                state_nxt = S_RD;
              end else begin
                ev_nxt    = fta_pkg::END_MARK;
                st_nxt    = fta_pkg::ST_RANGE;
                state_nxt = S_OUT;
              end
            end
            fta_pkg::KIND_WRITE: begin
              if (idx_in_range) begin
                mem_we    = 1'b1;
                mem_waddr = in_index[EW-1:0];
                mem_wdata = in_value;
              end else begin
                st_nxt = fta_pkg::ST_RANGE;
              end
              state_nxt = S_OUT;
            end
            fta_pkg::KIND_ALLOC: begin
              need_nxt      = (in_size_bytes == '0) ? NW'(1)
                            : NW'(size_sum / NW'(fta_pkg::CLUSTER_BYTES));
              cursor_nxt    = (EW+1)'(2);
              have_prev_nxt = 1'b0;
              state_nxt     = S_ARD;
            end
            default: begin
              if (in_index < IW'(fta_pkg::PACKED_BYTES)) begin
                state_nxt = S_PDIV;
              end else begin
                st_nxt    = fta_pkg::ST_RANGE;
                state_nxt = S_OUT;
              end
            end
          endcase
        end
      end
      S_RD: begin
        ev_nxt    = rdata_r;
        state_nxt = S_OUT;
      end
      S_PDIV: begin
        pair_nxt  = div_q;
        part_nxt  = div_rem[1:0];
        state_nxt = S_PLO;
      end
      S_PLO: begin
        mem_raddr = lo_addr[EW-1:0];
        lo_ok_nxt = (lo_addr < IW'(fta_pkg::ENTRIES));
        state_nxt = S_PHI;
      end
      S_PHI: begin
        mem_raddr = hi_addr[EW-1:0];
        hi_ok_nxt = (hi_addr < IW'(fta_pkg::ENTRIES));
        lo_nxt    = lo_ok_r ? rdata_r : '0;
        state_nxt = S_PBYTE;
      end
      S_PBYTE: begin
        case (part_r)
          2'd0:    bv_nxt = lo_r[7:0];
          2'd1:    bv_nxt = {hi_val[3:0], lo_r[11:8]};
          default: bv_nxt = hi_val[11:4];
        endcase
        state_nxt = S_OUT;
      end
      S_ARD: begin
        if (NW'(cnt_r) >= need_r) begin
          state_nxt = S_OUT;
        end else if (cursor_r > (EW+1)'(lim)) begin
          st_nxt    = fta_pkg::ST_FULL;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_ACHK;
        end
      end
      S_ACHK: begin
        cursor_nxt = cursor_r + (EW+1)'(1);
        state_nxt  = S_ARD;
        if (rdata_r == '0) begin
          // take this entry as the new chain end
          mem_we    = 1'b1;
          mem_waddr = cursor_r[EW-1:0];
          mem_wdata = fta_pkg::END_MARK;
          cnt_nxt   = cnt_r + VW'(1);
          found_nxt = cursor_r[EW-1:0];
          if (have_prev_r) begin
            state_nxt = S_ALINK;
          end else begin
            ev_nxt        = VW'(cursor_r[EW-1:0]);
            prev_nxt      = cursor_r[EW-1:0];
            have_prev_nxt = 1'b1;
          end
        end
      end
      S_ALINK: begin
        // point the previous chain end at the entry just taken
        mem_we    = 1'b1;
        mem_waddr = prev_r;
        mem_wdata = VW'(found_r);
        prev_nxt  = found_r;
        state_nxt = S_ARD;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      last_r  <= fta_pkg::RESET_LAST;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (cfg_we) begin
        last_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pair_r      <= pair_nxt;
    part_r      <= part_nxt;
    lo_r        <= lo_nxt;
    lo_ok_r     <= lo_ok_nxt;
    hi_ok_r     <= hi_ok_nxt;
    need_r      <= need_nxt;
    cursor_r    <= cursor_nxt;
    prev_r      <= prev_nxt;
    found_r     <= found_nxt;
    have_prev_r <= have_prev_nxt;
    ev_r        <= ev_nxt;
    bv_r        <= bv_nxt;
    cnt_r       <= cnt_nxt;
    st_r        <= st_nxt;
  end

endmodule
